// File: src/afr_pkg.sv
`timescale 1ns / 1ps

package afr_pkg;

    // Configuration register indexes
    localparam int AFR_CFG_IDX_W = 2;
    localparam logic [AFR_CFG_IDX_W-1:0] AFR_REG_ADDRESS = 2'd0;
    localparam logic [AFR_CFG_IDX_W-1:0] AFR_REG_COMMAND = 2'd1;
    localparam logic [AFR_CFG_IDX_W-1:0] AFR_REG_SKIP    = 2'd2;

    // Answer command carries the request command with this bit set
    localparam logic [7:0] AFR_ACK_BIT = 8'h80;

    // Default depth of the result queue between parser and output stage
    localparam int AFR_QUEUE_DEPTH = 4;

    // Output stream packing
    localparam int AFR_M_TDATA_W = 32;

    // Result kinds
    localparam logic AFR_KIND_PAYLOAD = 1'b0;
    localparam logic AFR_KIND_STATUS  = 1'b1;

    // Frame status codes
    localparam logic [2:0] AFR_ST_OK       = 3'd0;
    localparam logic [2:0] AFR_ST_REJECT   = 3'd1;
    localparam logic [2:0] AFR_ST_CHECKSUM = 3'd2;
    localparam logic [2:0] AFR_ST_NO_ADDR  = 3'd3;
    localparam logic [2:0] AFR_ST_TIMEOUT  = 3'd4;

    // Parser phases
    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_LEN   = 6'b000010,
        PH_CMD   = 6'b000100,
        PH_SKIP  = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_CHECK = 6'b100000
    } afr_phase_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [7:0] expected_address;
        logic [7:0] request_command;
        logic [7:0] skip_count;
    } afr_cfg_t;

    // One result item as it travels through the queue
    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [2:0] status;
        logic [7:0] data_length;
    } afr_result_t;

endpackage

// File: src/afr_front.sv
`timescale 1ns / 1ps

module afr_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    input  logic                              s_tuser,   // [0] action
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [afr_pkg::AFR_CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                        cfg_data,
    input  logic                              q_full,
    output logic                              push,
    output afr_pkg::afr_result_t              push_data
);
    import afr_pkg::*;

    afr_cfg_t   cfg_reg;
    afr_phase_t phase_reg, phase_next;
    logic [7:0] csum_reg, csum_next;
    logic [7:0] skip_rem_reg, skip_rem_next;
    logic [7:0] data_rem_reg, data_rem_next;
    logic [7:0] data_pos_reg, data_pos_next;
    logic       accept;
    logic [9:0] len_wide;
    logic       len_pos;
    afr_phase_t after_cmd_phase;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    // Payload length after the command: L - 2 - skip, clamped at zero
    assign len_wide = {2'b00, data_rem_reg} - 10'd2 - {2'b00, cfg_reg.skip_count};
    assign len_pos  = !len_wide[9] && (len_wide != 10'd0);
    assign after_cmd_phase = (cfg_reg.skip_count != 8'd0) ? PH_SKIP :
                             (len_pos ? PH_DATA : PH_CHECK);

    // Hold configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                AFR_REG_ADDRESS: cfg_reg.expected_address <= cfg_data;
                AFR_REG_COMMAND: cfg_reg.request_command  <= cfg_data;
                AFR_REG_SKIP:    cfg_reg.skip_count       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Parse one item per transfer and classify its result
    always_comb begin
        phase_next    = phase_reg;
        csum_next     = csum_reg;
        skip_rem_next = skip_rem_reg;
        data_rem_next = data_rem_reg;
        data_pos_next = data_pos_reg;
        push          = 1'b0;
        push_data     = '0;
        if (accept) begin
            if (s_tuser) begin
                push              = 1'b1;
                push_data.kind    = AFR_KIND_STATUS;
                push_data.status  = (phase_reg == PH_HUNT) ? AFR_ST_NO_ADDR : AFR_ST_TIMEOUT;
                phase_next        = PH_HUNT;
            end else begin
                case (phase_reg)
                    PH_HUNT: begin
                        if (s_tdata == cfg_reg.expected_address) begin
                            csum_next  = s_tdata;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        csum_next     = csum_reg ^ s_tdata;
                        data_rem_next = s_tdata;
                        phase_next    = PH_CMD;
                    end
                    PH_CMD: begin
                        if (s_tdata != (cfg_reg.request_command | AFR_ACK_BIT)) begin
                            push             = 1'b1;
                            push_data.kind   = AFR_KIND_STATUS;
                            push_data.status = AFR_ST_REJECT;
                            phase_next       = PH_HUNT;
                        end else begin
                            csum_next     = csum_reg ^ s_tdata;
                            data_rem_next = len_pos ? len_wide[7:0] : 8'd0;
                            data_pos_next = 8'd0;
                            skip_rem_next = cfg_reg.skip_count;
                            phase_next    = after_cmd_phase;
                        end
                    end
                    PH_SKIP: begin
                        csum_next     = csum_reg ^ s_tdata;
                        skip_rem_next = skip_rem_reg - 8'd1;
                        if (skip_rem_reg == 8'd1) begin
                            phase_next = (data_rem_reg != 8'd0) ? PH_DATA : PH_CHECK;
                        end
                    end
                    PH_DATA: begin
                        csum_next               = csum_reg ^ s_tdata;
                        push                    = 1'b1;
                        push_data.kind          = AFR_KIND_PAYLOAD;
                        push_data.payload_byte  = s_tdata;
                        push_data.payload_index = data_pos_reg;
                        data_pos_next           = data_pos_reg + 8'd1;
                        data_rem_next           = data_rem_reg - 8'd1;
                        if (data_rem_reg == 8'd1) begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        push           = 1'b1;
                        push_data.kind = AFR_KIND_STATUS;
                        if (s_tdata == csum_reg) begin
                            push_data.status      = AFR_ST_OK;
                            push_data.data_length = data_pos_reg;
                        end else begin
                            push_data.status = AFR_ST_CHECKSUM;
                        end
                        phase_next = PH_HUNT;
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // Advance parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            csum_reg     <= '0;
            skip_rem_reg <= '0;
            data_rem_reg <= '0;
            data_pos_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            csum_reg     <= csum_next;
            skip_rem_reg <= skip_rem_next;
            data_rem_reg <= data_rem_next;
            data_pos_reg <= data_pos_next;
        end
    end

endmodule

// File: src/afr_queue.sv
`timescale 1ns / 1ps

module afr_queue #(
    parameter int DEPTH = afr_pkg::AFR_QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  afr_pkg::afr_result_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 q_valid,
    output afr_pkg::afr_result_t q_data
);
    import afr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    afr_result_t      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Store pushed results
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// File: src/afr_back.sv
`timescale 1ns / 1ps

module afr_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  afr_pkg::afr_result_t                 q_data,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [afr_pkg::AFR_M_TDATA_W-1:0]    m_tdata,
    output logic                                 m_tuser
);
    import afr_pkg::*;

    logic        out_valid_reg;
    afr_result_t out_data_reg;

    // Take the queue head whenever the output register is free or drains
    assign pop = q_valid && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result until its transfer completes
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= q_data;
        end
    end

    // Pack fields from the lowest bit up, zero fill to whole bytes
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.kind;
    assign m_tdata  = {5'b00000,
                       out_data_reg.data_length,
                       out_data_reg.status,
                       out_data_reg.payload_index,
                       out_data_reg.payload_byte};

endmodule

// File: src/answer_frame_receiver_top.sv
`timescale 1ns / 1ps

// Answer frame receiver. Takes one received byte or timeout event per transfer on the
// s_ stream (tuser = 1 marks a timeout) and returns payload bytes and a final frame
// status on the m_ stream (tuser = 0 payload, 1 status). A parser takes one item every
// clock cycle while s_tready is high; each result reaches m_tvalid through a small
// result queue and an output register. s_tready drops only while that queue
// (QUEUE_DEPTH entries) is full, so the input keeps its full rate for as long as the
// output side keeps up. Configuration writes are always taken (cfg_ready stays high) and
// must only be issued while no frame is in progress.
module answer_frame_receiver_top #(
    parameter int QUEUE_DEPTH = afr_pkg::AFR_QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    input  logic                              s_tuser,   // [0] action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [18:16] status,
    // [26:19] data_length, [31:27] zero
    output logic [afr_pkg::AFR_M_TDATA_W-1:0] m_tdata,
    output logic                              m_tuser,   // [0] kind
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [afr_pkg::AFR_CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                        cfg_data
);
    import afr_pkg::*;

    logic        q_full, push, pop, q_valid;
    afr_result_t push_data, q_data;

    afr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    afr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    afr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: src/afr_checker.sv
`timescale 1ns / 1ps

module afr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [afr_pkg::AFR_M_TDATA_W-1:0] m_tdata,
    input logic                              m_tuser
);
    import afr_pkg::*;

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Payload results carry no status and no length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == AFR_KIND_PAYLOAD) |-> m_tdata[26:16] == 11'd0)
        else $error("payload result with status or length");

    // Failed frames report zero length, no payload byte and no payload index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == AFR_KIND_STATUS) && (m_tdata[18:16] != AFR_ST_OK)
        |-> m_tdata[26:19] == 8'd0 && m_tdata[15:0] == 16'd0)
        else $error("error status with nonzero fields");

    // Status code stays in range and fill bits stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:16] <= AFR_ST_TIMEOUT) && (m_tdata[31:27] == 5'd0))
        else $error("bad status code or fill bits");

endmodule

bind answer_frame_receiver_top afr_checker u_afr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
